### hw/rtl/hbq_pkg.sv
// ----------------------------------------------------------------------------
// hbq_pkg
// shared types, codes and defaults of the binary min-heap queue
// ----------------------------------------------------------------------------
package hbq_pkg;

  localparam int DEF_CAPACITY = 1024;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         payload;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key;
    logic [7:0]         payload;
    logic [10:0]        count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_TOP_RD,
    S_TOP_CAP,
    S_DN_RD,
    S_DN_CH,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

### hw/rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// array-backed min-heap priority queue of signed keys with byte payloads
// ----------------------------------------------------------------------------
// latency, accept to response transfer, grows with the heap depth for insert and
//   remove, set by one read and compare per heap level; peek and the empty, full
//   and unused commands do not walk the heap
// throughput: one command at a time, next accepted once the result is registered
// reset: synchronous, empties the heap; storage is not cleared
module binary_min_heap_queue #(
  parameter int CAPACITY = hbq_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // key[31:0], payload[39:32]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // min_key[31:0], min_payload[39:32], count[50:40]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import hbq_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  entry_t          in_entry;
  result_t         res;
  logic            res_valid, res_ready;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr_a, mem_raddr_b;
  entry_t          mem_wdata, mem_rdata_a, mem_rdata_b;
  logic signed [31:0] cmp_a, cmp_b;
  logic            cmp_lt;
  result_t         out_res;

  assign in_entry.key     = s_axis_tdata[31:0];
  assign in_entry.payload = s_axis_tdata[39:32];

  hbq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_cmd      (s_axis_tuser),
    .in_entry    (in_entry),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b),
    .cmp_a       (cmp_a),
    .cmp_b       (cmp_b),
    .cmp_lt      (cmp_lt)
  );

  hbq_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  hbq_less u_less (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  // output register, free when empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {5'b0, out_res.count, out_res.payload, out_res.key};
  assign m_axis_tuser = out_res.status;

endmodule

### hw/rtl/hbq_mem.sv
// ----------------------------------------------------------------------------
// hbq_mem
// heap entry storage, one write port and two registered read ports
// ----------------------------------------------------------------------------
module hbq_mem #(
  parameter int DEPTH = hbq_pkg::DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  hbq_pkg::entry_t            wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr_a,
  input  logic [$clog2(DEPTH)-1:0]   raddr_b,
  output hbq_pkg::entry_t            rdata_a,
  output hbq_pkg::entry_t            rdata_b
);
  import hbq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hw/rtl/hbq_less.sv
// ----------------------------------------------------------------------------
// hbq_less
// shared signed key compare, a strictly below b
// ----------------------------------------------------------------------------
module hbq_less (
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               lt
);

  assign lt = (a < b);

endmodule

### hw/rtl/hbq_ctrl.sv
// ----------------------------------------------------------------------------
// hbq_ctrl
// command sequencer, sift up and sift down with a held entry and a moving hole
// ----------------------------------------------------------------------------
module hbq_ctrl #(
  parameter int CAPACITY = hbq_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  hbq_pkg::entry_t               in_entry,
  output logic                          res_valid,
  input  logic                          res_ready,
  output hbq_pkg::result_t              res,
  output logic                          mem_we,
  output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
  output hbq_pkg::entry_t               mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]   mem_raddr_a,
  output logic [$clog2(CAPACITY)-1:0]   mem_raddr_b,
  input  hbq_pkg::entry_t               mem_rdata_a,
  input  hbq_pkg::entry_t               mem_rdata_b,
  output logic signed [31:0]            cmp_a,
  output logic signed [31:0]            cmp_b,
  input  logic                          cmp_lt
);
  import hbq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int EW = (CW > 11) ? CW : 11;

  state_t          state, state_next;
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   pos;
  logic [AW-1:0]   cidx;
  logic [1:0]      cmd;
  entry_t          hold;
  entry_t          child;
  logic [1:0]      res_status;
  entry_t          res_entry;

  logic            accept;
  logic [AW-1:0]   parent;
  logic [XW-1:0]   c1, c2;
  logic            c1_ok, c2_ok;
  logic [EW-1:0]   cnt_ext;

  assign accept  = in_valid && in_ready;
  assign parent  = (pos - 1'b1) >> 1;
  assign c1      = (XW'(pos) << 1) + XW'(1);
  assign c2      = (XW'(pos) << 1) + XW'(2);
  assign c1_ok   = c1 < XW'(cnt);
  assign c2_ok   = c2 < XW'(cnt);
  assign cnt_ext = EW'(cnt);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_INSERT: state_next = (cnt == CW'(CAPACITY)) ? S_DONE : S_INS_RD;
            CMD_REMOVE, CMD_PEEK: state_next = (cnt == '0) ? S_DONE : S_TOP_RD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_INS_RD:  state_next = (pos == '0) ? S_DONE : S_INS_CMP;
      S_INS_CMP: state_next = cmp_lt ? S_INS_RD : S_DONE;
      S_TOP_RD:  state_next = S_TOP_CAP;
      S_TOP_CAP: state_next = (cmd == CMD_REMOVE) ? S_DN_RD : S_DONE;
      S_DN_RD:   state_next = c1_ok ? S_DN_CH : S_DONE;
      S_DN_CH:   state_next = S_DN_CMP;
      S_DN_CMP:  state_next = cmp_lt ? S_DN_RD : S_DONE;
      S_DONE:    state_next = res_ready ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    res_valid   = (state == S_DONE);
    mem_we      = 1'b0;
    mem_waddr   = pos;
    mem_wdata   = hold;
    mem_raddr_a = parent;
    mem_raddr_b = AW'(cnt - 1'b1);
    cmp_a       = hold.key;
    cmp_b       = mem_rdata_a.key;
    case (state)
      S_INS_RD: begin
        mem_we = (pos == '0);
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata = mem_rdata_a;
        end
      end
      S_TOP_RD: begin
        mem_raddr_a = '0;
      end
      S_DN_RD: begin
        mem_we      = !c1_ok;
        mem_raddr_a = c1[AW-1:0];
        mem_raddr_b = c2[AW-1:0];
      end
      S_DN_CH: begin
        cmp_a = mem_rdata_b.key;
        cmp_b = mem_rdata_a.key;
      end
      S_DN_CMP: begin
        cmp_a  = child.key;
        cmp_b  = hold.key;
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata = child;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept && in_cmd == CMD_INSERT && cnt != CW'(CAPACITY)) begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TOP_CAP: begin
          if (cmd == CMD_REMOVE) begin
            cnt <= cnt - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd       <= in_cmd;
          hold      <= in_entry;
          pos       <= cnt[AW-1:0];
          res_entry <= '0;
          if (in_cmd == CMD_INSERT && cnt == CW'(CAPACITY)) begin
            res_status <= ST_FULL;
          end else if ((in_cmd == CMD_REMOVE || in_cmd == CMD_PEEK) && cnt == '0) begin
            res_status <= ST_EMPTY;
          end else begin
            res_status <= ST_OK;
          end
        end
      end
      S_INS_CMP: begin
        if (cmp_lt) begin
          pos <= parent;
        end
      end
      S_TOP_CAP: begin
        res_entry <= mem_rdata_a;
        hold      <= mem_rdata_b;
        pos       <= '0;
      end
      S_DN_CH: begin
        if (c2_ok && cmp_lt) begin
          child <= mem_rdata_b;
          cidx  <= c2[AW-1:0];
        end else begin
          child <= mem_rdata_a;
          cidx  <= c1[AW-1:0];
        end
      end
      S_DN_CMP: begin
        if (cmp_lt) begin
          pos <= cidx;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.status  = res_status;
  assign res.key     = res_entry.key;
  assign res.payload = res_entry.payload;
  assign res.count   = cnt_ext[10:0];

endmodule
